FILE: rtl/fidct_pkg.sv
// Shared types, constants and arithmetic helpers for the 4x4 forward integer
// transform with level shift. No dependencies; imported by the core module.
`default_nettype none

package fidct_pkg;

  localparam int PixelW      = 8;
  localparam int RowW        = 11;   // row-pass results
  localparam int WideW       = 14;   // working width of both passes
  localparam int CoefW       = 13;   // final coefficients
  localparam int LevelOffset = 128;
  localparam int InDataW     = 4 * PixelW;
  localparam int OutDataW    = ((4 * CoefW + 7) / 8) * 8;

  typedef logic        [PixelW-1:0] pixel_t;
  typedef logic signed [RowW-1:0]   rowv_t;
  typedef logic signed [WideW-1:0]  wide_t;
  typedef logic signed [CoefW-1:0]  coef_t;
  typedef wide_t [3:0]              wide4_t;

  // Four-point core transform with weights
  // (1,1,1,1 / 2,1,-1,-2 / 1,-1,-1,1 / 1,-2,2,-1).
  function automatic wide4_t core4(input wide4_t x);
    wide_t  s03;
    wide_t  s12;
    wide_t  d03;
    wide_t  d12;
    wide4_t y;
    s03  = x[0] + x[3];
    s12  = x[1] + x[2];
    d03  = x[0] - x[3];
    d12  = x[1] - x[2];
    y[0] = s03 + s12;
    y[1] = (d03 <<< 1) + d12;
    y[2] = s03 - s12;
    y[3] = d03 - (d12 <<< 1);
    return y;
  endfunction

  // Level shift of an unsigned pixel into the working width.
  function automatic wide_t level_shift(input pixel_t p);
    return wide_t'({{(WideW-PixelW){1'b0}}, p}) - wide_t'(LevelOffset);
  endfunction

  // (v + 1) >> 1 with floor rounding.
  function automatic coef_t round_half(input wide_t v);
    logic signed [WideW:0] t;
    t = {v[WideW-1], v} + {{WideW{1'b0}}, 1'b1};
    return t[CoefW:1];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/forward_int_dct4x4_level_shift_core.sv
// Top level of the 4x4 forward integer transform with level shift.
// Depends on fidct_pkg for types, the core transform and rounding.
`default_nettype none

//  Channel   | Direction | Contents of one word
//  ----------+-----------+------------------------------------------------------
//  s_axis    | in        | tdata: pixel_0..pixel_3, one row of four pixels
//  m_axis    | out       | tdata: coef_0..coef_3, tuser: coef_row, tlast: last_row
//
//  Each accepted input word is written by the row pass into the transpose
//  store at that edge. The fourth row sets the pending column pass flag; the
//  column pass then fills the four-row output buffer once it is free, and the
//  buffer drains one word per cycle while m_axis_tready_i is high.
//  The column pass waits while the output buffer still holds rows other than
//  a departing last row, and input stalls only during that wait.
//  Reset clears the row counter and all valid flags; data registers are
//  left unreset.

module forward_int_dct4x4_level_shift_core
  import fidct_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid_i,
  output      logic                s_axis_tready_o,
  // Fields from bit 0 up: pixel_0 [7:0], pixel_1, pixel_2, pixel_3 [31:24].
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  output      logic                m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // Fields from bit 0 up: coef_0 [12:0], coef_1, coef_2, coef_3 [51:39],
  // zero padding [55:52].
  output      logic [OutDataW-1:0] m_axis_tdata_o,
  // Fields from bit 0 up: coef_row [1:0].
  output      logic [1:0]          m_axis_tuser_o,
  output      logic                m_axis_tlast_o
);

  // Row counter, transpose store and pending column pass flag.
  logic [1:0] row_cnt_q, row_cnt_d;
  rowv_t      store_q [4][4];
  logic       col_go_q, col_go_d;

  // Output buffer of four coefficient rows.
  coef_t      coef_q [4][4];
  logic       out_valid_q, out_valid_d;
  logic [1:0] out_row_q, out_row_d;

  logic   in_fire;
  logic   out_fire;
  logic   buf_free;
  logic   load;
  wide4_t px;
  wide4_t row_res;
  coef_t  coef_d [4][4];

  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;

  // The buffer can take a new block when it is empty or its last row leaves now.
  assign buf_free = !out_valid_q || (out_fire && (out_row_q == 2'd3));
  assign load     = col_go_q && buf_free;

  // While a column pass waits, the store must keep the finished block.
  assign s_axis_tready_o = !col_go_q || buf_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // Row pass: level shift and core transform of the incoming row.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      px[i] = level_shift(s_axis_tdata_i[i*PixelW +: PixelW]);
    end
    row_res = core4(px);
  end

  // Column pass over the stored block, then rounding.
  always_comb begin
    wide4_t col;
    wide4_t res;
    for (int j = 0; j < 4; j++) begin
      for (int i = 0; i < 4; i++) begin
        col[i] = wide_t'(store_q[i][j]);
      end
      res = core4(col);
      for (int i = 0; i < 4; i++) begin
        coef_d[i][j] = round_half(res[i]);
      end
    end
  end

  always_comb begin
    row_cnt_d   = row_cnt_q;
    col_go_d    = col_go_q;
    out_valid_d = out_valid_q;
    out_row_d   = out_row_q;
    if (out_fire) begin
      out_row_d = out_row_q + 2'd1;
      if (out_row_q == 2'd3) begin
        out_valid_d = 1'b0;
      end
    end
    if (load) begin
      col_go_d    = 1'b0;
      out_valid_d = 1'b1;
      out_row_d   = 2'd0;
    end
    if (in_fire) begin
      row_cnt_d = row_cnt_q + 2'd1;
      if (row_cnt_q == 2'd3) begin
        col_go_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q   <= 2'd0;
      col_go_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_row_q   <= 2'd0;
    end else begin
      row_cnt_q   <= row_cnt_d;
      col_go_q    <= col_go_d;
      out_valid_q <= out_valid_d;
      out_row_q   <= out_row_d;
    end
  end

  // Transpose store: one row written per accepted word.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int j = 0; j < 4; j++) begin
        store_q[row_cnt_q][j] <= row_res[j][RowW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      coef_q <= coef_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_row_q;
  assign m_axis_tlast_o  = (out_row_q == 2'd3);
  assign m_axis_tdata_o  = {{(OutDataW - 4*CoefW){1'b0}},
                            coef_q[out_row_q][3], coef_q[out_row_q][2],
                            coef_q[out_row_q][1], coef_q[out_row_q][0]};

  // The fourth row of a block always schedules a column pass.
  a_row3_schedules: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (row_cnt_q == 2'd3)) |=> col_go_q)
    else $error("fourth row accepted without a column pass");

  // While a column pass is pending, no row of the next block has entered.
  a_pending_holds_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_go_q |-> (row_cnt_q == 2'd0))
    else $error("store overwritten while a column pass is pending");

  // A pending pass that cannot load keeps waiting.
  a_pending_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_go_q && !buf_free) |=> (col_go_q && out_valid_q))
    else $error("column pass lost while the buffer was busy");

  // Rows of a block leave in order.
  a_row_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && (out_row_q != 2'd3)) |=>
      (out_valid_q && (out_row_q == $past(out_row_q) + 2'd1)))
    else $error("coefficient rows out of order");

  // After the last row leaves, the buffer refills only from a pending pass.
  a_refill_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && (out_row_q == 2'd3)) |=> (out_valid_q == $past(col_go_q)))
    else $error("output buffer refilled without a column pass");

endmodule

`default_nettype wire
